@@ design/link_lag_fault_watchdog_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Link lag fault watchdog assertion macros
// Shared property forms for the checker.
// ----------------------------------------------------------------------------
`ifndef LINK_LAG_FAULT_WATCHDOG_UNIT_ASSERT_SVH
`define LINK_LAG_FAULT_WATCHDOG_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define LLFW_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("llfw assertion failed");

// next-cycle implication, disabled during reset
`define LLFW_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("llfw assertion failed");

`endif

@@ design/llfw_pkg.sv @@
// ----------------------------------------------------------------------------
// llfw_pkg
// Types and constants shared by the link lag fault watchdog.
// ----------------------------------------------------------------------------
package llfw_pkg;

	localparam int unsigned TimeW = 32;
	localparam int unsigned TripW = 8;

	localparam logic [TripW-1:0] TRIP_LIMIT = 8'd10;
	localparam logic [TripW-1:0] TRIP_MAX   = 8'd255;

	localparam logic [TimeW-1:0] LAG_DISC_RESET   = 32'd4000;
	localparam logic [TimeW-1:0] LAG_MOTOR_RESET  = 32'd300;
	localparam logic [TimeW-1:0] RETRY_INT_RESET  = 32'd10000;

	// register index, from paddr[3:2]
	typedef enum logic [1:0] {
		REG_LAG_DISC  = 2'd0,
		REG_LAG_MOTOR = 2'd1,
		REG_RETRY_INT = 2'd2
	} reg_idx_t;

	typedef enum logic [2:0] {
		REASON_NONE     = 3'd0,
		REASON_LAG_DISC = 3'd1,
		REASON_MOTOR    = 3'd2,
		REASON_TRIP     = 3'd3,
		REASON_BAD_DISC = 3'd4
	} reason_t;

	typedef struct packed {
		logic [TimeW-1:0] lag_disconnect_ms;
		logic [TimeW-1:0] lag_motor_stop_ms;
		logic [TimeW-1:0] retry_interval_ms;
	} cfg_t;

	typedef struct packed {
		logic             slot;
		logic             link_up;
		logic [TimeW-1:0] now_ms;
		logic [TimeW-1:0] last_message_ms;
		logic             data_sane;
	} item_t;

	typedef struct packed {
		logic    fault;
		reason_t reason;
		logic    disconnect;
	} res_t;

endpackage

@@ design/llfw_cfg.sv @@
// ----------------------------------------------------------------------------
// llfw_cfg
// APB register file holding the lag and retry limits.
// ----------------------------------------------------------------------------
module llfw_cfg import llfw_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);

	cfg_t     cfg_q;
	logic     wr_en;
	reg_idx_t idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign idx    = reg_idx_t'(paddr[3:2]);
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lag_disconnect_ms <= LAG_DISC_RESET;
			cfg_q.lag_motor_stop_ms <= LAG_MOTOR_RESET;
			cfg_q.retry_interval_ms <= RETRY_INT_RESET;
		end else if (wr_en) begin
			case (idx)
				REG_LAG_DISC:  cfg_q.lag_disconnect_ms <= pwdata;
				REG_LAG_MOTOR: cfg_q.lag_motor_stop_ms <= pwdata;
				REG_RETRY_INT: cfg_q.retry_interval_ms <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_LAG_DISC:  prdata = cfg_q.lag_disconnect_ms;
			REG_LAG_MOTOR: prdata = cfg_q.lag_motor_stop_ms;
			REG_RETRY_INT: prdata = cfg_q.retry_interval_ms;
			default:       prdata = 32'd0;
		endcase
	end

endmodule

@@ design/llfw_core.sv @@
// ----------------------------------------------------------------------------
// llfw_core
// Per-slot watchdog state and the single-pass fault decision.
// ----------------------------------------------------------------------------
module llfw_core import llfw_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  item_t item,
	input  cfg_t  cfg,
	output res_t  res
);

	logic [1:0]       rp_q;
	logic [TimeW-1:0] retry_q [2];
	logic [TripW-1:0] trip_q [2];

	logic             rp_cur;
	logic [TimeW-1:0] rs_cur;
	logic [TripW-1:0] tc_cur;
	logic             rp_nx;
	logic [TimeW-1:0] rs_nx;
	logic [TripW-1:0] tc_nx;
	logic [TimeW:0]   diff;
	logic [TimeW-1:0] lag;
	logic [TimeW-1:0] deadline;

	assign rp_cur   = rp_q[item.slot];
	assign rs_cur   = retry_q[item.slot];
	assign tc_cur   = trip_q[item.slot];
	assign diff     = {1'b0, item.now_ms} - {1'b0, item.last_message_ms};
	assign deadline = rs_cur + cfg.retry_interval_ms;

	// pending reconnect or message in the future: zero lag
	assign lag = (rp_cur || diff[TimeW]) ? '0 : diff[TimeW-1:0];

	always_comb begin
		rp_nx = rp_cur;
		rs_nx = rs_cur;
		tc_nx = tc_cur;
		res   = '{fault: 1'b0, reason: REASON_NONE, disconnect: 1'b0};
		if (!item.link_up) begin
			rp_nx = rp_cur | item.slot;
		end else begin
			rp_nx = 1'b0;
			if (lag > cfg.lag_disconnect_ms) begin
				res = '{fault: 1'b1, reason: REASON_LAG_DISC, disconnect: 1'b1};
			end else if (!item.slot && lag > cfg.lag_motor_stop_ms) begin
				res = '{fault: 1'b1, reason: REASON_MOTOR, disconnect: 1'b0};
			end else if (!item.data_sane && rs_cur != '0 && item.now_ms > deadline) begin
				tc_nx = (tc_cur == TRIP_MAX) ? tc_cur : tc_cur + 8'd1;
				rs_nx = '0;
				res   = '{fault: 1'b1, reason: REASON_TRIP, disconnect: 1'b0};
			end else begin
				if (!item.data_sane) begin
					if (rs_cur == '0)
						rs_nx = item.now_ms;
				end else if (tc_cur != '0) begin
					rs_nx = '0;
					tc_nx = '0;
				end
				if (tc_nx > TRIP_LIMIT)
					res = '{fault: 1'b1, reason: REASON_BAD_DISC, disconnect: 1'b1};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q       <= '0;
			retry_q[0] <= '0;
			retry_q[1] <= '0;
			trip_q[0]  <= '0;
			trip_q[1]  <= '0;
		end else if (en) begin
			rp_q[item.slot]    <= rp_nx;
			retry_q[item.slot] <= rs_nx;
			trip_q[item.slot]  <= tc_nx;
		end
	end

endmodule

@@ design/link_lag_fault_watchdog_unit.sv @@
// ----------------------------------------------------------------------------
// Link lag fault watchdog
// Lag and bad-data watchdog for a primary and a secondary controller link.
// ----------------------------------------------------------------------------
// Usage:
//   Each poll beat on s_axis carries the slot in tuser and the link status,
//   times and data-sane flag in tdata. One result beat per poll leaves on
//   m_axis with fault, reason and disconnect.
//   Limits sit in three APB registers (0x0 lag disconnect, 0x4 motor-stop
//   lag, 0x8 retry interval); write them only while no poll is in flight.
//   The input register, then the result register, lie between an accepted
//   poll and its result beat. Throughput: one poll per cycle while m_axis
//   does not stall; the per-slot state is read and updated in the single
//   decision stage, so a poll sees everything its predecessor left.
//   When m_axis stalls, the result register holds its beat and the input
//   register still takes one more poll; s_axis_tready drops after that.
//   Reset clears the limits to their defaults, the reconnect flags, retry
//   timers and trip counters, and empties both registers.
// ----------------------------------------------------------------------------
module link_lag_fault_watchdog_unit import llfw_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [71:0] s_axis_tdata,  // link_up, now_ms[32:1], last_message_ms[64:33], data_sane
	input  logic        s_axis_tuser,  // slot
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,  // fault, reason[3:1], disconnect[4]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	cfg_t  cfg;
	item_t item_s1;
	logic  valid_s1;
	res_t  res;
	res_t  res_q;
	logic  out_valid_q;
	logic  adv;

	llfw_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	llfw_core u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (adv),
		.item  (item_s1),
		.cfg   (cfg),
		.res   (res)
	);

	assign adv           = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1.slot            <= s_axis_tuser;
			item_s1.link_up         <= s_axis_tdata[0];
			item_s1.now_ms          <= s_axis_tdata[32:1];
			item_s1.last_message_ms <= s_axis_tdata[64:33];
			item_s1.data_sane       <= s_axis_tdata[65];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv)
			res_q <= res;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'b000, res_q.disconnect, res_q.reason, res_q.fault};

endmodule

@@ design/llfw_checker.sv @@
// ----------------------------------------------------------------------------
// llfw_props
// Port-level checks on the watchdog result stream.
// ----------------------------------------------------------------------------
`include "link_lag_fault_watchdog_unit_assert.svh"

module llfw_props import llfw_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [7:0]  m_axis_tdata
);

	logic [2:0] rsn;
	assign rsn = m_axis_tdata[3:1];

	// a stalled result beat holds
	`LLFW_ASSERT_NXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

	// fault is raised exactly when a reason is given
	`LLFW_ASSERT_IMP(a_fault_reason, clk, arst_n, m_axis_tvalid, m_axis_tdata[0] == (rsn != REASON_NONE))

	// only the two disconnect reasons drop the link
	`LLFW_ASSERT_IMP(a_disc_reason, clk, arst_n, m_axis_tvalid, m_axis_tdata[4] == (rsn == REASON_LAG_DISC || rsn == REASON_BAD_DISC))

	// no reason code beyond the bad-data disconnect, no stray upper bits
	`LLFW_ASSERT_IMP(a_reason_range, clk, arst_n, m_axis_tvalid, rsn <= REASON_BAD_DISC && m_axis_tdata[7:5] == 3'b000)

endmodule

bind link_lag_fault_watchdog_unit llfw_props u_llfw_props (.*);

@@ dv/llfw_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Link lag fault watchdog checker
// Watches the poll, result and register channels, keeps its own copy of the
// per-slot watchdog state and limits, and matches every result beat against
// the verdict predicted for the oldest outstanding poll.
// ----------------------------------------------------------------------------
module llfw_checker import llfw_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [71:0] s_axis_tdata,  // link_up, now_ms[32:1], last_message_ms[64:33], data_sane
	input  logic        s_axis_tuser,  // slot
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [7:0]  m_axis_tdata,  // fault, reason[3:1], disconnect[4]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int unsigned polls_seen,
	output int unsigned results_seen,
	output int unsigned faults_seen,
	output int unsigned err_cnt
);

	cfg_t             limits;
	logic             reconn_pend [2];
	logic [TimeW-1:0] retry_start [2];
	logic [TripW-1:0] trips       [2];
	res_t             verdict_q   [$];

	int unsigned n_polls, n_results, n_faults, n_errs;

	function automatic res_t verdict(logic f, reason_t r, logic d);
		res_t v;
		v.fault      = f;
		v.reason     = r;
		v.disconnect = d;
		return v;
	endfunction

	// updates the per-slot state the same way the block does for one poll
	function automatic res_t judge_poll(item_t p);
		logic             s;
		logic [TimeW-1:0] last;
		logic [TimeW-1:0] lag;
		logic [TimeW-1:0] deadline;
		s    = p.slot;
		last = p.last_message_ms;
		if (!p.link_up) begin
			if (s)
				reconn_pend[1] = 1'b1;
			return verdict(1'b0, REASON_NONE, 1'b0);
		end
		if (reconn_pend[s]) begin
			reconn_pend[s] = 1'b0;
			last = p.now_ms;
		end
		lag = (p.now_ms >= last) ? p.now_ms - last : '0;
		if (lag > limits.lag_disconnect_ms)
			return verdict(1'b1, REASON_LAG_DISC, 1'b1);
		if (!s && lag > limits.lag_motor_stop_ms)
			return verdict(1'b1, REASON_MOTOR, 1'b0);
		if (!p.data_sane) begin
			if (retry_start[s] != '0) begin
				deadline = retry_start[s] + limits.retry_interval_ms;
				if (p.now_ms > deadline) begin
					if (trips[s] < TRIP_MAX)
						trips[s] = trips[s] + 1'b1;
					retry_start[s] = '0;
					return verdict(1'b1, REASON_TRIP, 1'b0);
				end
			end else begin
				retry_start[s] = p.now_ms;
			end
		end else if (trips[s] != '0) begin
			retry_start[s] = '0;
			trips[s]       = '0;
		end
		if (trips[s] > TRIP_LIMIT)
			return verdict(1'b1, REASON_BAD_DISC, 1'b1);
		return verdict(1'b0, REASON_NONE, 1'b0);
	endfunction

	task automatic log_mismatch(input string msg);
		$display("[%0t] MISMATCH: %s", $realtime, msg);
		n_errs++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		item_t       poll;
		res_t        want;
		logic [2:0]  got_reason;
		if (!arst_n) begin
			limits.lag_disconnect_ms = LAG_DISC_RESET;
			limits.lag_motor_stop_ms = LAG_MOTOR_RESET;
			limits.retry_interval_ms = RETRY_INT_RESET;
			for (int i = 0; i < 2; i++) begin
				reconn_pend[i] = 1'b0;
				retry_start[i] = '0;
				trips[i]       = '0;
			end
			verdict_q.delete();
			n_polls   = 0;
			n_results = 0;
			n_faults  = 0;
			n_errs    = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_LAG_DISC:  limits.lag_disconnect_ms = pwdata;
					REG_LAG_MOTOR: limits.lag_motor_stop_ms = pwdata;
					REG_RETRY_INT: limits.retry_interval_ms = pwdata;
					default: ;
				endcase
			end
			// result first: a beat can never belong to a poll taken at the same edge
			if (m_axis_tvalid && m_axis_tready) begin
				n_results++;
				got_reason = m_axis_tdata[3:1];
				if (verdict_q.size() == 0) begin
					log_mismatch($sformatf("result beat %0h with no poll outstanding",
						m_axis_tdata));
				end else begin
					want = verdict_q.pop_front();
					if (m_axis_tdata[0] !== want.fault)
						log_mismatch($sformatf("result %0d fault %b, predicted %b",
							n_results, m_axis_tdata[0], want.fault));
					if (got_reason !== want.reason)
						log_mismatch($sformatf("result %0d reason %0d, predicted %0d",
							n_results, got_reason, want.reason));
					if (m_axis_tdata[4] !== want.disconnect)
						log_mismatch($sformatf("result %0d disconnect %b, predicted %b",
							n_results, m_axis_tdata[4], want.disconnect));
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				poll.slot            = s_axis_tuser;
				poll.link_up         = s_axis_tdata[0];
				poll.now_ms          = s_axis_tdata[32:1];
				poll.last_message_ms = s_axis_tdata[64:33];
				poll.data_sane       = s_axis_tdata[65];
				want = judge_poll(poll);
				if (want.fault)
					n_faults++;
				verdict_q.push_back(want);
				n_polls++;
			end
		end
		polls_seen   <= n_polls;
		results_seen <= n_results;
		faults_seen  <= n_faults;
		err_cnt      <= n_errs;
	end

endmodule

@@ dv/link_lag_fault_watchdog_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Link lag fault watchdog testbench
// Drives directed and random polls through several limit settings and idling
// patterns; a checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module link_lag_fault_watchdog_unit_tb;
	import llfw_pkg::*;

	localparam int          QUIET_LIMIT  = 2000;
	localparam int          PHASE_POLLS  = 250;
	localparam int          SAT_TRIPS    = 262;
	localparam logic [1:0]  REG_UNUSED   = 2'd3;

	logic        clk;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [71:0] s_axis_tdata  = '0;
	logic        s_axis_tuser  = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;
	logic        psel          = 1'b0;
	logic        penable       = 1'b0;
	logic        pwrite        = 1'b0;
	logic [3:0]  paddr         = '0;
	logic [31:0] pwdata        = '0;
	logic [31:0] prdata;
	logic        pready;

	int unsigned polls_seen, results_seen, faults_seen, err_cnt;

	int unsigned      send_idle_pct  = 0;
	int unsigned      recv_stall_pct = 0;
	int unsigned      n_sent         = 0;
	int unsigned      phase_sent;
	int unsigned      quiet          = 0;
	logic [TimeW-1:0] lim_disc       = LAG_DISC_RESET;
	logic [TimeW-1:0] lim_motor      = LAG_MOTOR_RESET;
	logic [TimeW-1:0] retry_iv       = RETRY_INT_RESET;
	logic [TimeW-1:0] time_ms [2]    = '{32'd1000, 32'd1000};

	link_lag_fault_watchdog_unit u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	llfw_checker u_chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.pready        (pready),
		.polls_seen    (polls_seen),
		.results_seen  (results_seen),
		.faults_seen   (faults_seen),
		.err_cnt       (err_cnt)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// ends the run when no beat or register access happens for too long
	always @(posedge clk) begin
		if (!arst_n || psel || (s_axis_tvalid && s_axis_tready) ||
				(m_axis_tvalid && m_axis_tready)) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("Watchdog: no beat for %0d cycles, %0d results outstanding",
					QUIET_LIMIT, polls_seen - results_seen);
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	task automatic send_poll(input logic slot, input logic up, input logic [31:0] now_v,
			input logic [31:0] last_v, input logic sane);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= slot;
		s_axis_tdata  <= {6'b0, sane, last_v, now_v, up};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		n_sent++;
		phase_sent++;
	endtask

	// lower valid and let every outstanding result come back
	task automatic drain_block();
		s_axis_tvalid <= 1'b0;
		repeat (2) @(posedge clk);
		while (polls_seen != results_seen)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_limits(input logic [31:0] disc, input logic [31:0] motor,
			input logic [31:0] retry);
		apb_write(REG_LAG_DISC, disc);
		apb_write(REG_LAG_MOTOR, motor);
		apb_write(REG_RETRY_INT, retry);
		lim_disc  = disc;
		lim_motor = motor;
		retry_iv  = retry;
	endtask

	// a run of polls, mostly on one slot, with moving time; mode picks how often data is bad
	task automatic run_burst(input int n);
		logic             s;
		int               mode;
		int               r;
		logic [TimeW-1:0] step;
		logic [TimeW-1:0] lag;
		logic [TimeW-1:0] lim;
		logic [TimeW-1:0] now_v;
		logic [TimeW-1:0] last_v;
		logic             sane;
		s    = 1'($urandom_range(1));
		mode = $urandom_range(2);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(99) < 12) begin
				send_poll(1'($urandom_range(1)), 1'($urandom_range(1)), $urandom, $urandom,
					1'($urandom_range(1)));
			end else begin
				case ($urandom_range(9))
					0, 1, 2, 3, 4: step = $urandom_range(50);
					5, 6, 7:       step = retry_iv + $urandom_range(2);
					8:             step = $urandom;
					default:       step = '0;
				endcase
				time_ms[s] = time_ms[s] + step;
				now_v = time_ms[s];
				lim   = s ? lim_disc : lim_motor;
				r     = $urandom_range(99);
				if (r < 8)
					lag = lim + $urandom_range(1);
				else if (r < 14)
					lag = lim_disc + $urandom_range(1);
				else if (r < 18)
					lag = -$urandom_range(1, 100);  // last message in the future
				else
					lag = $urandom_range(0, (lim < 200) ? lim : 200);
				last_v = now_v - lag;
				case (mode)
					0:       sane = ($urandom_range(99) >= 5);
					1:       sane = ($urandom_range(99) < 3);
					default: sane = 1'($urandom_range(1));
				endcase
				send_poll(s, ($urandom_range(99) >= 6), now_v, last_v, sane);
			end
		end
	endtask

	initial begin
		logic             s;
		logic [TimeW-1:0] t;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int ph = 0; ph < 6; ph++) begin
			if (ph > 0)
				drain_block();
			case (ph)
				1: begin
					set_limits('0, '0, '0);
					apb_write(REG_UNUSED, $urandom);  // no register behind this one
				end
				2: set_limits('1, '1, '1);
				3: set_limits($urandom_range(1000, 6000), $urandom_range(50, 900),
					$urandom_range(1, 20000));
				4: set_limits(32'd100, 32'd20, '0);
				5: set_limits($urandom_range(200, 3000), $urandom_range(0, 199),
					$urandom_range(0, 5000));
				default: ;
			endcase
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
				1: begin send_idle_pct = 51; recv_stall_pct <= 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct <= 51; end
				default: begin send_idle_pct = 28; recv_stall_pct <= 28; end
			endcase
			phase_sent = 0;

			if (ph == 0) begin
				send_poll(1'b0, 1'b0, 32'd100, 32'd0, 1'b1);        // primary down
				send_poll(1'b1, 1'b0, 32'd100, 32'd0, 1'b1);        // secondary down
				send_poll(1'b1, 1'b1, 32'd100000, 32'd0, 1'b1);     // reconnect, lag ignored
				send_poll(1'b1, 1'b1, 32'd104001, 32'd100000, 1'b1);
				send_poll(1'b1, 1'b1, 32'd104000, 32'd100000, 1'b1);
				send_poll(1'b1, 1'b1, 32'd5301, 32'd5000, 1'b1);    // no motor check here
				send_poll(1'b0, 1'b1, 32'd5301, 32'd5000, 1'b1);
				send_poll(1'b0, 1'b1, 32'd5300, 32'd5000, 1'b1);
				send_poll(1'b0, 1'b1, 32'd5000, 32'd5005, 1'b1);    // future message
				send_poll(1'b0, 1'b1, 32'd0, 32'd0, 1'b0);          // arming at zero stays idle
				send_poll(1'b0, 1'b1, 32'd10, 32'd10, 1'b0);
				send_poll(1'b0, 1'b1, 32'd10010, 32'd10010, 1'b0);  // on the deadline
				send_poll(1'b0, 1'b1, 32'd10011, 32'd10011, 1'b0);  // trip
				send_poll(1'b0, 1'b1, 32'd10012, 32'd10012, 1'b1);  // clears the trip
				send_poll(1'b0, 1'b1, 32'd20000, 32'd20000, 1'b0);
				send_poll(1'b0, 1'b1, 32'd20001, 32'd20001, 1'b1);  // no trips, timer kept
				send_poll(1'b0, 1'b1, 32'd30001, 32'd30001, 1'b0);
				send_poll(1'b1, 1'b1, '1, '0, 1'b0);
				send_poll(1'b1, 1'b1, '1, '1, 1'b1);
				send_poll(1'b0, 1'b1, '1, '1, 1'b0);
				send_poll(1'b0, 1'b0, '1, '1, 1'b0);
				send_poll(1'b1, 1'b1, '0, '1, 1'b0);
			end

			// zero retry interval: back-to-back bad polls trip up to saturation
			if (ph == 4) begin
				s = 1'($urandom_range(1));
				for (int k = 0; k < SAT_TRIPS; k++) begin
					t = time_ms[s] + 1;
					if (t == '0)
						t = 1;
					send_poll(s, 1'b1, t, t, 1'b0);
					send_poll(s, 1'b1, t + 1, t + 1, 1'b0);
					time_ms[s] = t + 1;
				end
				send_poll(s, 1'b1, time_ms[s], time_ms[s], 1'b1);
			end

			while (phase_sent < PHASE_POLLS)
				run_burst($urandom_range(5, 40));
		end

		drain_block();
		repeat (8) @(posedge clk);
		$display("Covered %0d polls over six limit settings and four idling patterns;",
			n_sent);
		$display("%0d results compared, %0d of them faults.", results_seen, faults_seen);
		if (err_cnt == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
